// ===== src/irc_tok_pkg.sv =====
// Shared types, constants and helpers for the IRC line tokenizer.
package irc_tok_pkg;

	localparam int unsigned MAX_LINE   = 510;
	localparam int unsigned MAX_PARAMS = 15;

	localparam int unsigned LINE_LEN_W = 10;
	localparam int unsigned PCOUNT_W   = 4;
	localparam int unsigned CLASS_W    = 3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'd32;

	localparam logic [CLASS_W-1:0] CLS_SOURCE  = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_USER    = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_HOST    = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_COMMAND = 3'd3;
	localparam logic [CLASS_W-1:0] CLS_PARAM   = 3'd4;

	localparam logic [LINE_LEN_W-1:0] LINE_LIMIT = LINE_LEN_W'(MAX_LINE);
	localparam logic [PCOUNT_W-1:0]   PARAM_LIMIT = PCOUNT_W'(MAX_PARAMS);

	typedef enum logic [2:0] {
		PH_LINE_START,
		PH_PREFIX,
		PH_COMMAND,
		PH_PARAMS,
		PH_TRAILING
	} phase_t;

	typedef struct packed {
		logic [LINE_LEN_W-1:0] line_len;
		phase_t                phase;
		logic                  prev_sep;
		logic [CLASS_W-1:0]    prefix_part;
		logic                  user_seen;
		logic                  host_seen;
		logic                  cmd_seen;
		logic [PCOUNT_W-1:0]   params_found;
		logic                  has_chars;
	} tok_state_t;

	typedef struct packed {
		logic                is_line_end;
		logic [CLASS_W-1:0]  token_class;
		logic                token_start;
		logic [PCOUNT_W-1:0] param_index;
		logic [7:0]          out_char;
		logic                has_command;
		logic [PCOUNT_W-1:0] param_count;
	} tok_result_t;

	localparam tok_state_t STATE_RESET = '{
		line_len:     '0,
		phase:        PH_LINE_START,
		prev_sep:     1'b0,
		prefix_part:  CLS_SOURCE,
		user_seen:    1'b0,
		host_seen:    1'b0,
		cmd_seen:     1'b0,
		params_found: '0,
		has_chars:    1'b0
	};

	function automatic logic [7:0] upcase(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
			r = c - CASE_OFS;
		end
		return r;
	endfunction

endpackage

// ===== src/irc_tok_step.sv =====
// Per-byte parser step: next line state and the result item for one byte.
module irc_tok_step import irc_tok_pkg::*; (
	input  tok_state_t  state,
	input  logic [7:0]  in_byte,
	output tok_state_t  next_state,
	output logic        emit,
	output tok_result_t result
);

	logic drop_byte;
	logic line_feed;
	logic over_len;
	logic sep_byte;
	logic prefix_delim;
	logic [PCOUNT_W-1:0] pf_inc;
	logic [PCOUNT_W-1:0] pf_cur;

	assign drop_byte    = (in_byte == CH_NUL) || (in_byte == CH_CR);
	assign line_feed    = (in_byte == CH_LF);
	assign over_len     = (state.line_len >= LINE_LIMIT);
	assign sep_byte     = (in_byte == CH_SPACE);
	assign prefix_delim = !state.host_seen &&
		(((in_byte == CH_BANG) && !state.user_seen) || (in_byte == CH_AT));
	assign pf_inc       = state.params_found + 1'b1;
	assign pf_cur       = state.params_found - 1'b1;

	// next state
	always_comb begin
		next_state = state;
		if (drop_byte) begin
			next_state = state;
		end else if (line_feed) begin
			next_state = STATE_RESET;
		end else if (!over_len) begin
			next_state.line_len = state.line_len + 1'b1;
			unique case (state.phase)
				PH_PREFIX: begin
					if (sep_byte) begin
						next_state.prev_sep = 1'b1;
					end else if (state.prev_sep) begin
						next_state.prev_sep  = 1'b0;
						next_state.cmd_seen  = 1'b1;
						next_state.phase     = PH_COMMAND;
						next_state.has_chars = 1'b1;
					end else if (prefix_delim) begin
						next_state.has_chars = 1'b0;
						if (in_byte == CH_AT) begin
							next_state.host_seen   = 1'b1;
							next_state.prefix_part = CLS_HOST;
						end else begin
							next_state.user_seen   = 1'b1;
							next_state.prefix_part = CLS_USER;
						end
					end else begin
						next_state.has_chars = 1'b1;
					end
				end
				PH_COMMAND, PH_PARAMS: begin
					if (sep_byte) begin
						next_state.prev_sep = 1'b1;
					end else if (state.prev_sep) begin
						next_state.prev_sep     = 1'b0;
						next_state.params_found = pf_inc;
						if (in_byte == CH_COLON) begin
							next_state.phase     = PH_TRAILING;
							next_state.has_chars = 1'b0;
						end else begin
							next_state.phase     = (pf_inc >= PARAM_LIMIT) ? PH_TRAILING
								: PH_PARAMS;
							next_state.has_chars = 1'b1;
						end
					end else begin
						next_state.has_chars = 1'b1;
					end
				end
				PH_TRAILING: begin
					next_state.has_chars = 1'b1;
				end
				default: begin
					next_state.prev_sep = 1'b0;
					if (in_byte == CH_COLON) begin
						next_state.phase       = PH_PREFIX;
						next_state.prefix_part = CLS_SOURCE;
						next_state.has_chars   = 1'b0;
					end else begin
						next_state.cmd_seen  = 1'b1;
						next_state.phase     = PH_COMMAND;
						next_state.has_chars = 1'b1;
					end
				end
			endcase
		end
	end

	// result item
	always_comb begin
		emit   = 1'b0;
		result = '0;
		if (drop_byte) begin
			emit = 1'b0;
		end else if (line_feed) begin
			emit               = 1'b1;
			result.is_line_end = 1'b1;
			result.has_command = state.cmd_seen;
			result.param_count = state.params_found;
		end else if (!over_len) begin
			unique case (state.phase)
				PH_PREFIX: begin
					if (sep_byte) begin
						emit = 1'b0;
					end else if (state.prev_sep) begin
						emit               = 1'b1;
						result.token_class = CLS_COMMAND;
						result.token_start = 1'b1;
						result.out_char    = upcase(in_byte);
					end else if (!prefix_delim) begin
						emit               = 1'b1;
						result.token_class = state.prefix_part;
						result.token_start = !state.has_chars;
						result.out_char    = in_byte;
					end
				end
				PH_COMMAND, PH_PARAMS: begin
					if (sep_byte) begin
						emit = 1'b0;
					end else if (state.prev_sep) begin
						// a leading colon opens the trailing parameter and is consumed
						if (in_byte != CH_COLON) begin
							emit               = 1'b1;
							result.token_class = CLS_PARAM;
							result.token_start = 1'b1;
							result.param_index = state.params_found;
							result.out_char    = in_byte;
						end
					end else if (state.phase == PH_COMMAND) begin
						emit               = 1'b1;
						result.token_class = CLS_COMMAND;
						result.token_start = !state.has_chars;
						result.out_char    = upcase(in_byte);
					end else begin
						emit               = 1'b1;
						result.token_class = CLS_PARAM;
						result.token_start = !state.has_chars;
						result.param_index = pf_cur;
						result.out_char    = in_byte;
					end
				end
				PH_TRAILING: begin
					emit               = 1'b1;
					result.token_class = CLS_PARAM;
					result.token_start = !state.has_chars;
					result.param_index = pf_cur;
					result.out_char    = in_byte;
				end
				default: begin
					if (in_byte != CH_COLON) begin
						emit               = 1'b1;
						result.token_class = CLS_COMMAND;
						result.token_start = 1'b1;
						result.out_char    = upcase(in_byte);
					end
				end
			endcase
		end
	end

endmodule

// ===== src/irc_line_tokenizer_core.sv =====
// Top level of the IRC line tokenizer: input register, parser step, result register.
// Takes one received byte per cycle unless a held result stalls it, and gives
// at most one result per byte: a classified token character, or a line summary
// on LF. NUL and CR are dropped, bytes past 510 in a line are dropped until LF.
// A byte passes through an input register and a result register before its
// result shows on the outputs; the line state updates as the byte leaves the
// input register, so a byte can be taken every cycle while results are drained,
// and the result register holds a finished result while the next byte waits in
// the input register.
module irc_line_tokenizer_core import irc_tok_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  logic [7:0]          in_byte,
	output logic                res_valid,
	input  logic                res_ready,
	output logic                is_line_end,
	output logic [CLASS_W-1:0]  token_class,
	output logic                token_start,
	output logic [PCOUNT_W-1:0] param_index,
	output logic [7:0]          out_char,
	output logic                has_command,
	output logic [PCOUNT_W-1:0] param_count
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	tok_state_t  state_q;
	tok_state_t  state_nxt;
	logic        emit;
	tok_result_t res_nxt;
	tok_result_t res_q;
	logic        res_valid_q;
	logic        out_free;
	logic        advance;

	irc_tok_step u_step (
		.state      (state_q),
		.in_byte    (byte_s1),
		.next_state (state_nxt),
		.emit       (emit),
		.result     (res_nxt)
	);

	assign out_free   = !res_valid_q || res_ready;
	// a byte with no result never waits on the output side
	assign advance    = valid_s1 && (!emit || out_free);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid   = res_valid_q;
	assign is_line_end = res_q.is_line_end;
	assign token_class = res_q.token_class;
	assign token_start = res_q.token_start;
	assign param_index = res_q.param_index;
	assign out_char    = res_q.out_char;
	assign has_command = res_q.has_command;
	assign param_count = res_q.param_count;

endmodule

// ===== src/irc_tok_checker.sv =====
// Port-level checks for the IRC line tokenizer, bound to the top level.
module irc_tok_checker import irc_tok_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input logic                is_line_end,
	input logic [CLASS_W-1:0]  token_class,
	input logic                token_start,
	input logic [PCOUNT_W-1:0] param_index,
	input logic [7:0]          out_char,
	input logic                has_command,
	input logic [PCOUNT_W-1:0] param_count
);

	// a stalled result stays valid and keeps its line-end flag, class, character and parameter count
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(is_line_end) &&
		$stable(token_class) && $stable(out_char) && $stable(param_count))
		else $error("result changed while stalled");

	a_line_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_line_end |-> token_class == CLS_SOURCE && !token_start &&
		param_index == '0 && out_char == '0)
		else $error("line summary carries token fields");

	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_line_end |-> !has_command && param_count == '0 &&
		(token_class == CLS_SOURCE || token_class == CLS_USER ||
		 token_class == CLS_HOST || token_class == CLS_COMMAND ||
		 token_class == CLS_PARAM))
		else $error("token character carries summary fields or bad class");

	a_cmd_upper: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_line_end && token_class == CLS_COMMAND |->
		!(out_char >= CH_LOW_A && out_char <= CH_LOW_Z) && param_index == '0)
		else $error("command character not uppercased");

	a_prefix_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_line_end && token_class != CLS_PARAM |-> param_index == '0)
		else $error("parameter index outside a parameter");

endmodule

bind irc_line_tokenizer_core irc_tok_checker u_irc_tok_checker (.*);
